[hdl/mavg_pkg.sv]
// Shared types and constants for the boxcar moving average filter.
// Used by mavg_div and moving_average_filter. No dependencies.
`default_nettype none

package mavg_pkg;

  localparam int MaxWindow  = 64;
  localparam int SampleBits = 16;
  localparam int AddrBits   = $clog2(MaxWindow);
  localparam int CntBits    = $clog2(MaxWindow + 1);
  localparam int SumBits    = SampleBits + AddrBits + 1;
  localparam int WinBits    = 7;
  localparam int DivCntBits = $clog2(SumBits + 1);

  localparam logic [WinBits-1:0] WinReset = WinBits'(8);

  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic                         last_sample;
  } in_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] average;
    logic                         window_full;
  } out_t;

  // divider status toward the control FSM
  typedef struct packed {
    logic                         done;
    logic signed [SampleBits-1:0] quot;
  } div_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

[hdl/mavg_div.sv]
// Bit-serial signed-by-unsigned divider, one quotient bit per cycle.
// Quotient truncates toward zero and saturates to the sample range. Uses mavg_pkg.
`default_nettype none

module mavg_div (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start_i,
  input  wire logic signed [mavg_pkg::SumBits-1:0]    dividend_i,
  input  wire logic        [mavg_pkg::CntBits-1:0]    divisor_i,
  output      mavg_pkg::div_res_t                     res_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [mavg_pkg::DivCntBits-1:0]  cnt_q, cnt_d;
  logic                             neg_q, neg_d;
  logic [mavg_pkg::SumBits-1:0]     dvd_q, dvd_d;
  logic [mavg_pkg::CntBits-1:0]     rem_q, rem_d;
  logic [mavg_pkg::CntBits-1:0]     dsr_q, dsr_d;
  logic [mavg_pkg::CntBits:0]       trial;
  logic                             ge;
  logic [mavg_pkg::SumBits-1:0]     mag;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    trial  = {rem_q, dvd_q[mavg_pkg::SumBits-1]};
    ge     = trial >= {1'b0, dsr_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = mavg_pkg::DivCntBits'(mavg_pkg::SumBits);
      neg_d  = dividend_i[mavg_pkg::SumBits-1];
      dvd_d  = dividend_i[mavg_pkg::SumBits-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits the divisor width
      rem_d = ge ? mavg_pkg::CntBits'(trial - {1'b0, dsr_q})
                 : mavg_pkg::CntBits'(trial);
      dvd_d = {dvd_q[mavg_pkg::SumBits-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == mavg_pkg::DivCntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  // sign and saturation of the magnitude quotient
  assign mag = dvd_q;

  always_comb begin
    res_o.done = done_q;
    if (neg_q) begin
      if (mag > mavg_pkg::SumBits'({1'b1, {(mavg_pkg::SampleBits-1){1'b0}}}))
        res_o.quot = {1'b1, {(mavg_pkg::SampleBits-1){1'b0}}};
      else
        res_o.quot = mavg_pkg::SampleBits'(~mag[mavg_pkg::SampleBits-1:0] + 1'b1);
    end else begin
      if (mag > mavg_pkg::SumBits'({1'b0, {(mavg_pkg::SampleBits-1){1'b1}}}))
        res_o.quot = {1'b0, {(mavg_pkg::SampleBits-1){1'b1}}};
      else
        res_o.quot = mag[mavg_pkg::SampleBits-1:0];
    end
  end

endmodule

`default_nettype wire

[hdl/moving_average_filter.sv]
// Boxcar moving average: input channel, output register, config write port.
// Depends on mavg_pkg and mavg_div.
//
// Usage:
//   Input beats (in_valid_i / in_stall_o) carry one signed sample and a
//   last_sample flag. Each beat gives exactly one output beat (out_valid_o /
//   out_stall_i) with the window mean, truncated toward zero, and a full flag.
//   Until window_size samples of a block have arrived the average is zero and
//   window_full is low. A beat with last_sample set ends the block.
//   Config: cfg_valid_i / cfg_ready_o writes window_size (0 acts as 1, above
//   64 acts as 64); write it only while no beat is in flight. Reset value 8.
// Timing:
//   One beat at a time: ST_IDLE, ST_UPDATE and ST_DONE while the window is
//   filling, with ST_DIV and its 23-step bit-serial divider once it is full.
//   The sample history sits in a 64 x 16 RAM with registered read; the leaving
//   sample is read at accept and the new one written in the next cycle.
//   The output register holds a result while the receiver stalls; the next
//   input beat is still taken and processed, waiting for that register only
//   at the end. Reset clears sum, fill count and write slot; no RAM clear is
//   needed since only slots written in the current block are read.
`default_nettype none

module moving_average_filter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire mavg_pkg::in_t                 in_data_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      mavg_pkg::out_t                out_data_o,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [mavg_pkg::WinBits-1:0]  cfg_data_i
);

  mavg_pkg::state_e                        state_q, state_d;
  logic signed [mavg_pkg::SumBits-1:0]     sum_q, sum_d, sum_new;
  logic [mavg_pkg::CntBits-1:0]            fill_q, fill_d, fill_new;
  logic [mavg_pkg::AddrBits-1:0]           slot_q, slot_d;
  logic [mavg_pkg::WinBits-1:0]            win_q;
  logic [mavg_pkg::CntBits-1:0]            weff;
  mavg_pkg::in_t                           smp_q;
  logic signed [mavg_pkg::SampleBits-1:0]  rd_q, leaving;
  logic [mavg_pkg::AddrBits-1:0]           rd_addr;
  logic signed [mavg_pkg::SampleBits-1:0]  res_q, res_d;
  logic                                    full_q, full_d, full_new;
  logic                                    out_valid_q, out_valid_d;
  mavg_pkg::out_t                          out_q, out_d;
  logic                                    accept, wr_en, div_start;
  mavg_pkg::div_res_t                      div_res;

  logic signed [mavg_pkg::SampleBits-1:0]  hist_mem [mavg_pkg::MaxWindow];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != mavg_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    if (win_q == '0)
      weff = mavg_pkg::CntBits'(1);
    else if (mavg_pkg::CntBits'(win_q) > mavg_pkg::CntBits'(mavg_pkg::MaxWindow))
      weff = mavg_pkg::CntBits'(mavg_pkg::MaxWindow);
    else
      weff = mavg_pkg::CntBits'(win_q);
  end

  // a window of MaxWindow wraps to the slot being overwritten
  assign rd_addr = slot_q - weff[mavg_pkg::AddrBits-1:0];

  assign leaving  = (fill_q >= weff) ? rd_q : '0;
  assign sum_new  = sum_q + mavg_pkg::SumBits'(smp_q.sample)
                          - mavg_pkg::SumBits'(leaving);
  assign fill_new = (fill_q < mavg_pkg::CntBits'(mavg_pkg::MaxWindow)) ?
                    fill_q + 1'b1 : fill_q;
  assign full_new = fill_new >= weff;

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    fill_d      = fill_q;
    slot_d      = slot_q;
    res_d       = res_q;
    full_d      = full_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr_en       = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      mavg_pkg::ST_IDLE: begin
        if (accept) state_d = mavg_pkg::ST_UPDATE;
      end
      mavg_pkg::ST_UPDATE: begin
        wr_en  = 1'b1;
        slot_d = slot_q + 1'b1;
        full_d = full_new;
        if (smp_q.last_sample) begin
          sum_d  = '0;
          fill_d = '0;
        end else begin
          sum_d  = sum_new;
          fill_d = fill_new;
        end
        if (full_new) begin
          div_start = 1'b1;
          state_d   = mavg_pkg::ST_DIV;
        end else begin
          res_d   = '0;
          state_d = mavg_pkg::ST_DONE;
        end
      end
      mavg_pkg::ST_DIV: begin
        if (div_res.done) begin
          res_d   = div_res.quot;
          state_d = mavg_pkg::ST_DONE;
        end
      end
      mavg_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.average     = res_q;
          out_d.window_full = full_q;
          state_d           = mavg_pkg::ST_IDLE;
        end
      end
      default: state_d = mavg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mavg_pkg::ST_IDLE;
      sum_q       <= '0;
      fill_q      <= '0;
      slot_q      <= '0;
      win_q       <= mavg_pkg::WinReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      fill_q      <= fill_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) win_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    full_q <= full_d;
    out_q  <= out_d;
    if (accept) smp_q <= in_data_i;
  end

  // history RAM: read the leaving sample at accept, write the new one in update
  always_ff @(posedge clk_i) begin
    if (wr_en) hist_mem[slot_q] <= smp_q.sample;
    if (accept) rd_q <= hist_mem[rd_addr];
  end

  mavg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_new),
    .divisor_i  (weff),
    .res_o      (div_res)
  );

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= mavg_pkg::CntBits'(mavg_pkg::MaxWindow))
    else $error("fill count above window depth");

  a_accept_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == mavg_pkg::ST_UPDATE)
    else $error("accepted beat not followed by update");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mavg_pkg::ST_UPDATE && smp_q.last_sample) |=>
      (fill_q == '0 && sum_q == '0))
    else $error("block end did not clear sum and fill count");

  a_slot_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mavg_pkg::ST_UPDATE |=>
      slot_q == mavg_pkg::AddrBits'($past(slot_q) + 1'b1))
    else $error("write slot did not advance by one");

  a_not_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.window_full) |-> out_data_o.average == '0)
    else $error("nonzero average before window is full");

endmodule

`default_nettype wire
